// ===== rtl/core/sia_pkg.sv =====
// Shared types and constants for the signed integer ALU core.
// No dependencies; imported by every module under rtl/core.
package sia_pkg;

    localparam int DefaultWidth = 64;
    localparam int FieldWidth   = 64;
    localparam int OpWidth      = 3;

    typedef enum logic [OpWidth-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4,
        OP_NEG = 3'd5,
        OP_NOP6 = 3'd6,
        OP_NOP7 = 3'd7
    } t_op;

    // Control that travels with an item down the cell chain.
    typedef struct packed {
        logic valid;
        t_op  op;
        logic an;
        logic bn;
        logic lt;
        logic eq;
        logic gt;
        logic dz;
    } t_ctl;

endpackage

// ===== rtl/core/sia_cell.sv =====
// One cell of the ALU chain: one restoring-divide step and one multiply
// partial-product step per cycle while i_en is high. Depends on sia_pkg.
module sia_cell #(
    parameter int WIDTH = sia_pkg::DefaultWidth,
    parameter int IDX   = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  sia_pkg::t_ctl        i_ctl,
    input  logic [WIDTH-1:0]     i_a,
    input  logic [WIDTH-1:0]     i_b,
    input  logic [WIDTH-1:0]     i_rem,
    input  logic [WIDTH-1:0]     i_quo,
    input  logic [WIDTH-1:0]     i_prod,
    output sia_pkg::t_ctl        o_ctl,
    output logic [WIDTH-1:0]     o_a,
    output logic [WIDTH-1:0]     o_b,
    output logic [WIDTH-1:0]     o_rem,
    output logic [WIDTH-1:0]     o_quo,
    output logic [WIDTH-1:0]     o_prod
);
    import sia_pkg::*;

    logic [WIDTH:0]   n_trial;
    logic [WIDTH:0]   n_shift;
    logic [WIDTH-1:0] n_rem;
    logic [WIDTH-1:0] n_quo;
    logic [WIDTH-1:0] n_prod;

    // i_a holds the dividend magnitude being shifted out, i_b the divisor
    // magnitude; the multiply works on the same two magnitudes.
    always_comb begin
        n_shift = {i_rem, i_a[WIDTH-1-IDX]};
        n_trial = n_shift - {1'b0, i_b};
        if (!n_trial[WIDTH]) begin
            n_rem = n_trial[WIDTH-1:0];
            n_quo = {i_quo[WIDTH-2:0], 1'b1};
        end else begin
            n_rem = n_shift[WIDTH-1:0];
            n_quo = {i_quo[WIDTH-2:0], 1'b0};
        end
        // Multiply of magnitudes, one bit of the multiplier per cell.
        n_prod = i_prod + (i_a[IDX] ? (i_b << IDX) : '0);
    end

    // Pipeline registers handing data to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.valid <= 1'b0;
        end else if (i_en) begin
            o_ctl.valid <= i_ctl.valid;
        end
        if (i_en) begin
            o_ctl.op <= i_ctl.op;
            o_ctl.an <= i_ctl.an;
            o_ctl.bn <= i_ctl.bn;
            o_ctl.lt <= i_ctl.lt;
            o_ctl.eq <= i_ctl.eq;
            o_ctl.gt <= i_ctl.gt;
            o_ctl.dz <= i_ctl.dz;
            o_a      <= i_a;
            o_b      <= i_b;
            o_rem    <= n_rem;
            o_quo    <= n_quo;
            o_prod   <= n_prod;
        end
    end

endmodule

// ===== rtl/core/signed_integer_alu_core.sv =====
// Top level of the signed integer ALU: input stage, a chain of WIDTH cells
// and an output stage. Depends on sia_pkg and sia_cell.
// An item passes the input register, the WIDTH cells and the output register in turn.
// Throughput: one item per cycle; the whole chain advances when the output
// register is empty or being taken, so up to WIDTH + 2 items are in flight.
// Reset clears all valid flags; no item is in flight after reset.
module signed_integer_alu_core #(
    parameter int WIDTH = sia_pkg::DefaultWidth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: operand_a [63:0], operand_b [127:64]
    input  logic [127:0] s_axis_tdata,
    // tuser: operation [2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: result_value [63:0], a_less [64], a_equal [65], a_greater [66],
    // divide_by_zero [67], zero fill [71:68]
    output logic [71:0] m_axis_tdata
);
    import sia_pkg::*;

    localparam int N = WIDTH;

    t_ctl             c_ctl  [0:N];
    logic [WIDTH-1:0] c_a    [0:N];
    logic [WIDTH-1:0] c_b    [0:N];
    logic [WIDTH-1:0] c_rem  [0:N];
    logic [WIDTH-1:0] c_quo  [0:N];
    logic [WIDTH-1:0] c_prod [0:N];

    logic             w_en;
    logic [WIDTH-1:0] w_a, w_b, w_ma, w_mb;
    logic             w_an, w_bn;
    t_ctl             n_ctl;

    logic             r_ovalid;
    logic [63:0]      r_res;
    logic [3:0]       r_flags;

    assign w_en          = !r_ovalid || m_axis_tready;
    assign s_axis_tready = w_en;

    // Input decode: compare flags and operand magnitudes.
    always_comb begin
        w_a  = s_axis_tdata[WIDTH-1:0];
        w_b  = s_axis_tdata[64 +: WIDTH];
        w_an = w_a[WIDTH-1];
        w_bn = w_b[WIDTH-1];
        w_ma = w_an ? (-w_a) : w_a;
        w_mb = w_bn ? (-w_b) : w_b;
        n_ctl.valid = s_axis_tvalid;
        n_ctl.op    = t_op'(s_axis_tuser);
        n_ctl.an    = w_an;
        n_ctl.bn    = w_bn;
        n_ctl.eq    = (w_a == w_b);
        n_ctl.lt    = $signed(w_a) < $signed(w_b);
        n_ctl.gt    = !n_ctl.lt && !n_ctl.eq;
        n_ctl.dz    = (w_b == '0) && (t_op'(s_axis_tuser) == OP_DIV ||
                                      t_op'(s_axis_tuser) == OP_MOD);
    end

    // Input register feeding the first cell; raw operands kept separately.
    logic [WIDTH-1:0] r_ra [0:N];
    logic [WIDTH-1:0] r_rb [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            c_ctl[0].valid <= 1'b0;
        end else if (w_en) begin
            c_ctl[0].valid <= n_ctl.valid;
        end
        if (w_en) begin
            c_ctl[0].op <= n_ctl.op;
            c_ctl[0].an <= n_ctl.an;
            c_ctl[0].bn <= n_ctl.bn;
            c_ctl[0].lt <= n_ctl.lt;
            c_ctl[0].eq <= n_ctl.eq;
            c_ctl[0].gt <= n_ctl.gt;
            c_ctl[0].dz <= n_ctl.dz;
            c_a[0]    <= w_ma;
            c_b[0]    <= w_mb;
            c_rem[0]  <= '0;
            c_quo[0]  <= '0;
            c_prod[0] <= '0;
            r_ra[0]   <= w_a;
            r_rb[0]   <= w_b;
        end
    end

    // The cell chain, with raw operands delayed alongside.
    for (genvar g = 0; g < N; g++) begin : g_cell
        sia_cell #(.WIDTH(WIDTH), .IDX(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_ctl  (c_ctl[g]),
            .i_a    (c_a[g]),
            .i_b    (c_b[g]),
            .i_rem  (c_rem[g]),
            .i_quo  (c_quo[g]),
            .i_prod (c_prod[g]),
            .o_ctl  (c_ctl[g+1]),
            .o_a    (c_a[g+1]),
            .o_b    (c_b[g+1]),
            .o_rem  (c_rem[g+1]),
            .o_quo  (c_quo[g+1]),
            .o_prod (c_prod[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ra[g+1] <= r_ra[g];
                r_rb[g+1] <= r_rb[g];
            end
        end
    end

    // Result selection from the end of the chain.
    t_ctl             e_ctl;
    logic [WIDTH-1:0] e_a, e_b, e_mb, e_m, e_q, e_p, n_r;

    always_comb begin
        e_ctl = c_ctl[N];
        e_a   = r_ra[N];
        e_b   = r_rb[N];
        e_mb  = c_b[N];
        e_q   = c_quo[N];
        e_p   = (e_ctl.an != e_ctl.bn) ? (-c_prod[N]) : c_prod[N];
        e_m   = c_rem[N];
        if (e_m != '0 && e_ctl.an != e_ctl.bn) begin
            e_m = e_mb - e_m;
        end
        case (e_ctl.op)
            OP_ADD: n_r = e_a + e_b;
            OP_SUB: n_r = e_a - e_b;
            OP_MUL: n_r = e_p;
            OP_DIV: begin
                if (e_ctl.dz) n_r = '1;
                else n_r = (e_ctl.an != e_ctl.bn) ? (-e_q) : e_q;
            end
            OP_MOD: begin
                if (e_ctl.dz) n_r = e_a;
                else n_r = e_ctl.bn ? (-e_m) : e_m;
            end
            OP_NEG: n_r = -e_a;
            default: n_r = '0;
        endcase
    end

    // Output register; it refills in the same cycle it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_en) begin
            r_ovalid <= e_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res   <= 64'($signed(n_r));
            r_flags <= {e_ctl.dz, e_ctl.gt, e_ctl.eq, e_ctl.lt};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'b0000, r_flags, r_res};

endmodule
